// ===== rtl/deq_pkg.sv =====
// Shared constants and codes for the ring-buffer double-ended queue.
`default_nettype none
package deq_pkg;

  localparam int MAX_DEPTH = 16;
  localparam int IDX_W     = $clog2(MAX_DEPTH);
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int CAP_IN_W  = 5;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;
  localparam int DATA_W    = 32;

  localparam int CAP_RESET_INT = (16 < MAX_DEPTH) ? 16 : MAX_DEPTH;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(CAP_RESET_INT);
  localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(MAX_DEPTH);

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DROP_FRONT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DROP_REAR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ_OUT   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/double_ended_queue_ring_top.sv =====
// Top level of the ring-buffer double-ended queue with its control sequencer.
//
// A request is taken when in_valid is high and in_stall is low; in_stall stays
// high while the sequencer works on a request. A push or drop is accepted,
// then makes one pass through the shared index unit and gives one result. A
// readout of N stored entries gives N results: for each entry the sequencer
// steps the walk pointer and issues the slot read, then moves the registered
// read data into the output register. An empty readout and action codes 5 to
// 7 give no result. One output register holds the pending result, so the
// final result of a request may wait on out_stall while the next request is
// already accepted. Writing the capacity register while idle empties the
// queue; slot contents are kept.
`default_nettype none
module double_ended_queue_ring_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic        [deq_pkg::CAP_IN_W-1:0] cfg_capacity_in_use,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic        [deq_pkg::ACT_W-1:0]    in_action,
  input  wire logic signed [deq_pkg::DATA_W-1:0]   in_item_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic             [deq_pkg::STAT_W-1:0]   out_status,
  output logic signed      [deq_pkg::DATA_W-1:0]   out_element_value,
  output logic             [deq_pkg::CNT_W-1:0]    out_entry_count,
  output logic                                     out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_ISSUE,
    ST_RD_EMIT
  } state_t;

  state_t                              state_r;
  logic        [deq_pkg::CNT_W-1:0]    cap_r;
  logic        [deq_pkg::IDX_W-1:0]    front_r;
  logic        [deq_pkg::IDX_W-1:0]    rear_r;
  logic        [deq_pkg::CNT_W-1:0]    count_r;
  logic        [deq_pkg::ACT_W-1:0]    act_r;
  logic signed [deq_pkg::DATA_W-1:0]   value_r;
  logic        [deq_pkg::IDX_W-1:0]    walk_r;
  logic        [deq_pkg::CNT_W-1:0]    rem_r;

  logic                                out_valid_r;
  logic        [deq_pkg::STAT_W-1:0]   out_status_r;
  logic signed [deq_pkg::DATA_W-1:0]   out_value_r;
  logic        [deq_pkg::CNT_W-1:0]    out_count_r;
  logic                                out_last_r;

  logic        [deq_pkg::IDX_W-1:0]    step_idx;
  logic                                step_up;
  logic        [deq_pkg::IDX_W-1:0]    step_out;
  logic                                out_free;
  logic                                is_front_op;
  logic                                is_push;
  logic                                is_drop;
  logic                                mem_we;
  logic                                mem_re;
  logic signed [deq_pkg::DATA_W-1:0]   mem_rdata;
  logic        [deq_pkg::CNT_W-1:0]    cap_clamped;
  logic        [deq_pkg::CNT_W-1:0]    cfg_ext;
  logic        [deq_pkg::CNT_W-1:0]    count_dec;

  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != ST_IDLE);
  assign is_front_op = (act_r == deq_pkg::ACT_PUSH_FRONT) || (act_r == deq_pkg::ACT_DROP_FRONT);
  assign is_push     = (act_r == deq_pkg::ACT_PUSH_FRONT) || (act_r == deq_pkg::ACT_PUSH_REAR);
  assign is_drop     = (act_r == deq_pkg::ACT_DROP_FRONT) || (act_r == deq_pkg::ACT_DROP_REAR);
  assign count_dec   = count_r - deq_pkg::CNT_W'(1);

  // The walk pointer always moves up; updates step front or rear by action.
  always_comb begin
    if (state_r == ST_RD_ISSUE) begin
      step_idx = walk_r;
      step_up  = 1'b1;
    end else begin
      step_idx = is_front_op ? front_r : rear_r;
      step_up  = (act_r == deq_pkg::ACT_PUSH_FRONT) || (act_r == deq_pkg::ACT_DROP_REAR);
    end
  end

  deq_step u_step (
    .idx     (step_idx),
    .cap     (cap_r),
    .up      (step_up),
    .idx_out (step_out)
  );

  assign mem_we = (state_r == ST_EXEC) && out_free && is_push && (count_r < cap_r);
  assign mem_re = (state_r == ST_RD_ISSUE);

  deq_slot_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (step_out),
    .wdata (value_r),
    .re    (mem_re),
    .raddr (walk_r),
    .rdata (mem_rdata)
  );

  always_comb begin
    cfg_ext = deq_pkg::CNT_W'(cfg_capacity_in_use);
    if (cfg_capacity_in_use == '0) begin
      cap_clamped = deq_pkg::CNT_W'(1);
    end else if (cfg_ext > deq_pkg::CAP_MAX) begin
      cap_clamped = deq_pkg::CAP_MAX;
    end else begin
      cap_clamped = cfg_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= deq_pkg::CAP_RESET;
      front_r     <= deq_pkg::IDX_W'(deq_pkg::CAP_RESET - deq_pkg::CNT_W'(1));
      rear_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cfg_wr_en) begin
            cap_r   <= cap_clamped;
            front_r <= deq_pkg::IDX_W'(cap_clamped - deq_pkg::CNT_W'(1));
            rear_r  <= '0;
            count_r <= '0;
          end
          if (in_valid) begin
            act_r   <= in_action;
            value_r <= in_item_value;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (act_r == deq_pkg::ACT_READ_OUT) begin
            walk_r  <= rear_r;
            rem_r   <= count_r;
            state_r <= (count_r == '0) ? ST_IDLE : ST_RD_ISSUE;
          end else if (!is_push && !is_drop) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= '0;
            out_last_r   <= 1'b1;
            out_status_r <= deq_pkg::STAT_OK;
            out_count_r  <= count_r;
            state_r      <= ST_IDLE;
            if (is_push) begin
              if (count_r >= cap_r) begin
                out_status_r <= deq_pkg::STAT_FULL;
              end else begin
                count_r     <= count_r + deq_pkg::CNT_W'(1);
                out_count_r <= count_r + deq_pkg::CNT_W'(1);
                if (is_front_op) begin
                  front_r <= step_out;
                  if (count_r == '0) begin
                    rear_r <= step_out;
                  end
                end else begin
                  rear_r <= step_out;
                  if (count_r == '0) begin
                    front_r <= step_out;
                  end
                end
              end
            end else begin
              if (count_r == '0) begin
                out_status_r <= deq_pkg::STAT_EMPTY;
              end else begin
                count_r     <= count_dec;
                out_count_r <= count_dec;
                if (count_dec == '0) begin
                  front_r <= deq_pkg::IDX_W'(cap_r - deq_pkg::CNT_W'(1));
                  rear_r  <= '0;
                end else if (is_front_op) begin
                  front_r <= step_out;
                end else begin
                  rear_r <= step_out;
                end
              end
            end
          end
        end
        ST_RD_ISSUE: begin
          walk_r  <= step_out;
          state_r <= ST_RD_EMIT;
        end
        ST_RD_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= deq_pkg::STAT_OK;
            out_value_r  <= mem_rdata;
            out_count_r  <= count_r;
            out_last_r   <= (rem_r == deq_pkg::CNT_W'(1));
            rem_r        <= rem_r - deq_pkg::CNT_W'(1);
            state_r      <= (rem_r == deq_pkg::CNT_W'(1)) ? ST_IDLE : ST_RD_ISSUE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_element_value = out_value_r;
  assign out_entry_count   = out_count_r;
  assign out_last          = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/deq_step.sv =====
// Shared ring index unit: steps an index up or down modulo the capacity in use.
`default_nettype none
module deq_step (
  input  wire logic [deq_pkg::IDX_W-1:0] idx,
  input  wire logic [deq_pkg::CNT_W-1:0] cap,
  input  wire logic                      up,
  output logic      [deq_pkg::IDX_W-1:0] idx_out
);

  logic [deq_pkg::CNT_W-1:0] cap_m1;
  logic [deq_pkg::CNT_W-1:0] idx_ext;

  assign cap_m1  = cap - deq_pkg::CNT_W'(1);
  assign idx_ext = deq_pkg::CNT_W'(idx);

  always_comb begin
    if (up) begin
      idx_out = (idx_ext == cap_m1) ? '0 : idx + deq_pkg::IDX_W'(1);
    end else begin
      idx_out = (idx == '0) ? cap_m1[deq_pkg::IDX_W-1:0] : idx - deq_pkg::IDX_W'(1);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/deq_slot_ram.sv =====
// Slot storage: one write port and one registered read port.
`default_nettype none
module deq_slot_ram (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic        [deq_pkg::IDX_W-1:0]  waddr,
  input  wire logic signed [deq_pkg::DATA_W-1:0] wdata,
  input  wire logic                              re,
  input  wire logic        [deq_pkg::IDX_W-1:0]  raddr,
  output logic signed      [deq_pkg::DATA_W-1:0] rdata
);

  logic signed [deq_pkg::DATA_W-1:0] mem [deq_pkg::MAX_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/deque_ring_checker.sv =====
// Checker for the ring-buffer deque: tracks its contents and compares every returned result.
module deque_ring_checker
  import deq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CAP_IN_W-1:0]      cfg_capacity_in_use,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [DATA_W-1:0] in_item_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [STAT_W-1:0]        out_status,
  input  logic signed [DATA_W-1:0] out_element_value,
  input  logic [CNT_W-1:0]         out_entry_count,
  input  logic                     out_last,
  output int                       fault_total,
  output int                       results_owed
);

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] element;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } deque_result_t;

  deque_result_t            owed_results[$];
  deque_result_t            seen;
  deque_result_t            want;
  logic signed [DATA_W-1:0] ring [MAX_DEPTH];
  int                       ring_size = CAP_RESET_INT;
  int                       head_pos = CAP_RESET_INT - 1;
  int                       tail_pos = 0;
  int                       held = 0;
  int                       faults = 0;

  initial begin
    fault_total = 0;
    results_owed = 0;
  end

  task automatic empty_ring();
    head_pos = ring_size - 1;
    tail_pos = 0;
    held = 0;
  endtask

  task automatic owe(input logic [STAT_W-1:0] stat, input logic signed [DATA_W-1:0] elem,
                     input int count, input logic fin);
    deque_result_t r;
    r.status = stat;
    r.element = elem;
    r.count = CNT_W'(count);
    r.last = fin;
    owed_results.push_back(r);
  endtask

  task automatic apply_request(input logic [ACT_W-1:0] act,
                               input logic signed [DATA_W-1:0] val);
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (held >= ring_size) begin
          owe(STAT_FULL, '0, held, 1'b1);
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            head_pos = (head_pos + 1) % ring_size;
            ring[head_pos] = val;
            if (held == 0) tail_pos = head_pos;
          end else begin
            tail_pos = (tail_pos + ring_size - 1) % ring_size;
            ring[tail_pos] = val;
            if (held == 0) head_pos = tail_pos;
          end
          held++;
          owe(STAT_OK, '0, held, 1'b1);
        end
      end
      ACT_DROP_FRONT, ACT_DROP_REAR: begin
        if (held == 0) begin
          owe(STAT_EMPTY, '0, 0, 1'b1);
        end else begin
          if (act == ACT_DROP_FRONT) head_pos = (head_pos + ring_size - 1) % ring_size;
          else tail_pos = (tail_pos + 1) % ring_size;
          held--;
          if (held == 0) empty_ring();
          owe(STAT_OK, '0, held, 1'b1);
        end
      end
      ACT_READ_OUT: begin
        for (int i = 0; i < held; i++)
          owe(STAT_OK, ring[(tail_pos + i) % ring_size], held, i == held - 1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ring_size = CAP_RESET_INT;
      empty_ring();
      owed_results.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_capacity_in_use == 0) ring_size = 1;
        else if (cfg_capacity_in_use > MAX_DEPTH) ring_size = MAX_DEPTH;
        else ring_size = cfg_capacity_in_use;
        empty_ring();
      end
      if (out_valid && !out_stall) begin
        seen.status = out_status;
        seen.element = out_element_value;
        seen.count = out_entry_count;
        seen.last = out_last;
        if (owed_results.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("%0t: unexpected result status %0d value %0d count %0d last %0d",
                     $realtime, seen.status, seen.element, seen.count, seen.last);
        end else begin
          want = owed_results.pop_front();
          if (want.status !== seen.status || want.element !== seen.element ||
              want.count !== seen.count || want.last !== seen.last) begin
            faults++;
            if (faults <= 10)
              $display("%0t: mismatch, expected status %0d value %0d count %0d last %0d, %s",
                       $realtime, want.status, want.element, want.count, want.last,
                       $sformatf("got status %0d value %0d count %0d last %0d",
                                 seen.status, seen.element, seen.count, seen.last));
          end
        end
      end
      if (in_valid && !in_stall) apply_request(in_action, in_item_value);
    end
    fault_total <= faults;
    results_owed <= owed_results.size();
  end

endmodule

// ===== tb/sv/double_ended_queue_ring_top_tb.sv =====
// Testbench top for the ring-buffer deque: drives requests and capacity writes, gives the verdict.
module double_ended_queue_ring_top_tb;
  import deq_pkg::*;

  localparam int IDLE_LIMIT     = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASES         = 10;
  localparam int PHASE_REQUESTS = 42;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [CAP_IN_W-1:0]      cfg_capacity_in_use = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [ACT_W-1:0]         in_action = ACT_PUSH_FRONT;
  logic signed [DATA_W-1:0] in_item_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_element_value;
  logic [CNT_W-1:0]         out_entry_count;
  logic                     out_last;
  int                       fault_total;
  int                       results_owed;
  logic                     steady = 1'b0;
  int                       stall_left = 0;
  int                       stall_roll;
  int                       idle_cycles = 0;

  double_ended_queue_ring_top dut (.*);

  deque_ring_checker checker_inst (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (steady) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 40) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(1, 25);
      end else if (stall_roll < 85) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 2);
      end else if (stall_roll < 97) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(3, 10);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(20, 50);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("double_ended_queue_ring_top_tb: errors");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 19))
      0: return {1'b0, {(DATA_W-1){1'b1}}};
      1: return {1'b1, {(DATA_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(input int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ACT_W'($urandom_range(ACT_READ_OUT + 1, 2 ** ACT_W - 1));
    if (r < 13) return ACT_READ_OUT;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
    return $urandom_range(0, 1) ? ACT_DROP_FRONT : ACT_DROP_REAR;
  endfunction

  task automatic send_request(input logic [ACT_W-1:0] act,
                              input logic signed [DATA_W-1:0] val);
    int gap;
    in_action <= act;
    in_item_value <= val;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic settle_and_configure(input logic [CAP_IN_W-1:0] cap_value);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_capacity_in_use <= cap_value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [CAP_IN_W-1:0] cap_pick;
    logic [ACT_W-1:0]    act;
    int                  eff;
    int                  push_pct;
    int                  burst;
    int                  sent;
    int                  mode;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // On an empty deque both drops are rejected; a readout and the spare codes return nothing.
    send_request(ACT_DROP_FRONT, random_value());
    send_request(ACT_DROP_REAR, random_value());
    send_request(ACT_READ_OUT, random_value());
    for (int a = ACT_READ_OUT + 1; a < 2 ** ACT_W; a++) send_request(ACT_W'(a), random_value());
    send_request(ACT_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_request(ACT_PUSH_REAR, 32'sh8000_0000);
    send_request(ACT_PUSH_FRONT, '0);
    send_request(ACT_PUSH_REAR, '1);
    send_request(ACT_PUSH_FRONT, 32'shAAAA_AAAA);
    send_request(ACT_PUSH_REAR, 32'sh5555_5555);
    send_request(ACT_READ_OUT, random_value());
    send_request(ACT_DROP_FRONT, random_value());
    send_request(ACT_DROP_REAR, random_value());
    send_request(ACT_READ_OUT, random_value());
    send_request(ACT_DROP_FRONT, random_value());
    send_request(ACT_DROP_REAR, random_value());
    send_request(ACT_DROP_FRONT, random_value());
    send_request(ACT_DROP_REAR, random_value());
    // Emptying the deque puts the pointers back, so this push lands in a fresh ring.
    send_request(ACT_PUSH_REAR, random_value());
    send_request(ACT_READ_OUT, random_value());

    // A capacity of zero is taken as one slot, which makes the full case easy to reach.
    settle_and_configure('0);
    send_request(ACT_PUSH_REAR, random_value());
    send_request(ACT_PUSH_FRONT, random_value());
    send_request(ACT_READ_OUT, random_value());
    send_request(ACT_DROP_FRONT, random_value());
    send_request(ACT_DROP_REAR, random_value());

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: cap_pick = '1;
        1: cap_pick = CAP_IN_W'(2);
        2: cap_pick = CAP_IN_W'(MAX_DEPTH);
        3: cap_pick = CAP_IN_W'(MAX_DEPTH + 1);
        4: cap_pick = CAP_IN_W'(3);
        5: cap_pick = '0;
        default: cap_pick = CAP_IN_W'($urandom_range(0, 2 ** CAP_IN_W - 1));
      endcase
      settle_and_configure(cap_pick);
      steady <= (p % 4 == 1);
      if (cap_pick == 0) eff = 1;
      else if (cap_pick > MAX_DEPTH) eff = MAX_DEPTH;
      else eff = cap_pick;
      sent = 0;
      burst = 0;
      push_pct = 50;
      while (sent < PHASE_REQUESTS) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 2 * eff + 2);
          mode = $urandom_range(0, 2);
          push_pct = (mode == 0) ? 85 : ((mode == 1) ? 15 : 50);
        end
        burst--;
        act = pick_action(push_pct);
        if (act <= ACT_READ_OUT) sent++;
        send_request(act, random_value());
        if ($urandom_range(0, 99) == 0) begin
          in_valid <= 1'b0;
          wait_drained();
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_total == 0 && results_owed == 0) begin
      $display("double_ended_queue_ring_top_tb: clean");
    end else begin
      $display("double_ended_queue_ring_top_tb: errors");
    end
    $finish;
  end

endmodule
